>>> src/abdsr_pkg.sv
// Shared types and constants of the archive block decryptor with seed recovery.
package abdsr_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned INDEX_W = 8;

    localparam logic [WORD_W-1:0] MIX_INIT   = 32'hEEEE_EEEE;
    localparam logic [WORD_W-1:0] KEY_ADD    = 32'h1111_1111;
    localparam logic [WORD_W-1:0] MIX_ADD    = 32'h0000_0003;
    localparam int unsigned       KEY_SHL    = 21;
    localparam int unsigned       KEY_SHR    = 11;
    localparam int unsigned       MIX_SHL    = 5;
    localparam logic [WORD_W-1:0] CHECK_MASK = 32'hFFFF_0000;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_START   = 2'd1,
        REQ_DECRYPT = 2'd2,
        REQ_RECOVER = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_MISMATCH  = 2'd2
    } t_status;

    typedef struct packed {
        t_req                 req_type;
        logic [INDEX_W-1:0]   table_index;
        logic [WORD_W-1:0]    word_a;
        logic [WORD_W-1:0]    word_b;
        logic [WORD_W-1:0]    known_plain;
        logic [WORD_W-1:0]    start_seed;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0]    plain_word;
        logic [WORD_W-1:0]    found_seed;
        t_status              status;
    } t_out_item;

    typedef struct packed {
        logic                 we;
        logic [INDEX_W-1:0]   addr;
        logic [WORD_W-1:0]    wdata;
    } t_ram_req;

endpackage

>>> src/abdsr_add3.sv
// Shared three-operand 32-bit adder used by every arithmetic step.
module abdsr_add3
    import abdsr_pkg::*;
(
    input  logic [WORD_W-1:0] i_x,
    input  logic [WORD_W-1:0] i_y,
    input  logic [WORD_W-1:0] i_z,
    output logic [WORD_W-1:0] o_sum
);

    // Modulo 2^32 sum, the carry out is dropped.
    assign o_sum = i_x + i_y + i_z;

endmodule

>>> src/abdsr_key_ram.sv
// Key table memory: 256 words, one write and one registered read per cycle, both at the same address.
module abdsr_key_ram
    import abdsr_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_req          i_req,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [2**INDEX_W];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/archive_block_decrypt_seed_recovery.sv
// Top level: sequencer, seed registers and result register of the block decryptor.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall  | o_out_item (t_out_item)
//
// A load or start item goes from acceptance through the execute state to a
// waiting result, and a decrypt item goes through the D states. A recover
// item tests candidates in turn; each one is rejected by the first-word
// check or by the second-word check, or passes both. The sequencer returns
// to idle before it takes the next item. The steps of the sequencer share
// the single adder and the one read port of the key table, so they run in
// turn.
// Reset is synchronous and active low; it clears the key seed to zero, sets the
// mixing seed to its start value and empties the result register. The key
// table is not cleared. The block takes a new item whenever the sequencer is
// idle, even while the previous result still waits under i_out_stall.
module archive_block_decrypt_seed_recovery
    import abdsr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // One-hot sequencer states. The D states decrypt one word, the R states
    // test one recovery candidate per pass.
    typedef enum logic [18:0] {
        S_IDLE = 19'h00001,
        S_EXEC = 19'h00002,
        S_DMIX = 19'h00004,
        S_DPLN = 19'h00008,
        S_DKEY = 19'h00010,
        S_DMX1 = 19'h00020,
        S_DMX2 = 19'h00040,
        S_RRD0 = 19'h00080,
        S_RS1  = 19'h00100,
        S_RRD1 = 19'h00200,
        S_RS2  = 19'h00400,
        S_RCH1 = 19'h00800,
        S_RK2  = 19'h01000,
        S_RMX1 = 19'h02000,
        S_RMX2 = 19'h04000,
        S_RMX3 = 19'h08000,
        S_RCH2 = 19'h10000,
        S_OUT  = 19'h20000,
        S_NEXT = 19'h40000
    } t_state;

    t_state             r_state, n_state;
    t_in_item           r_item,  n_item;
    logic [WORD_W-1:0]  r_key,   n_key;
    logic [WORD_W-1:0]  r_mix,   n_mix;
    logic [WORD_W-1:0]  r_tmp_m, n_tmp_m;
    logic [WORD_W-1:0]  r_plain, n_plain;
    logic [WORD_W-1:0]  r_base,  n_base;
    logic [WORD_W-1:0]  r_s1,    n_s1;
    logic [WORD_W-1:0]  r_s2,    n_s2;
    logic [WORD_W-1:0]  r_k2,    n_k2;
    logic [INDEX_W-1:0] r_idx,   n_idx;
    t_out_item          r_res,   n_res;
    t_out_item          r_out,   n_out;
    logic               r_out_valid, n_out_valid;

    t_ram_req           ram_req;
    logic [WORD_W-1:0]  ram_rdata;
    logic [WORD_W-1:0]  add_x, add_y, add_z, add_sum;
    logic               out_take;
    logic               slot_free;

    abdsr_key_ram u_key_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    abdsr_add3 u_add (
        .i_x   (add_x),
        .i_y   (add_y),
        .i_z   (add_z),
        .o_sum (add_sum)
    );

    assign out_take  = r_out_valid && !i_out_stall;
    assign slot_free = !r_out_valid || out_take;

    // Operand selection for the shared adder and address selection for the
    // table read port, both decided by the current state and, in the execute state, by the request type.
    always_comb begin
        add_x         = r_s2;
        add_y         = '0;
        add_z         = '0;
        ram_req.we    = 1'b0;
        ram_req.addr  = r_idx;
        ram_req.wdata = r_item.word_a;
        unique case (r_state)
            S_EXEC: begin
                if (r_item.req_type == REQ_LOAD) begin
                    ram_req.we   = 1'b1;
                    ram_req.addr = r_item.table_index;
                end else begin
                    ram_req.addr = r_key[INDEX_W-1:0];
                end
                // Candidate base: (a ^ known) - MIX_INIT.
                add_x = r_item.word_a ^ r_item.known_plain;
                add_y = ~MIX_INIT;
                add_z = WORD_W'(1);
            end
            S_DMIX: begin
                add_x = r_mix;
                add_y = ram_rdata;
            end
            S_DPLN: begin
                add_x = r_key;
                add_y = r_tmp_m;
            end
            S_DKEY: begin
                add_x = (~r_key) << KEY_SHL;
                add_y = KEY_ADD;
            end
            S_DMX1: begin
                add_x = r_plain;
                add_y = r_tmp_m;
                add_z = r_tmp_m << MIX_SHL;
            end
            S_DMX2: begin
                add_x = r_mix;
                add_y = MIX_ADD;
            end
            S_RS1: begin
                add_x = r_base;
                add_y = ~ram_rdata;
                add_z = WORD_W'(1);
            end
            S_RRD1: begin
                ram_req.addr = r_s1[INDEX_W-1:0];
            end
            S_RS2: begin
                add_x = MIX_INIT;
                add_y = ram_rdata;
            end
            S_RCH1: begin
                add_x = r_s1;
                add_y = r_s2;
            end
            S_RK2: begin
                add_x = (~r_s1) << KEY_SHL;
                add_y = KEY_ADD;
            end
            S_RMX1: begin
                // The first word matched, so its plaintext is the known value.
                add_x = r_item.known_plain;
                add_y = r_s2;
                add_z = r_s2 << MIX_SHL;
            end
            S_RMX2: begin
                add_x        = r_s2;
                add_y        = MIX_ADD;
                ram_req.addr = r_k2[INDEX_W-1:0];
            end
            S_RMX3: begin
                add_x = r_s2;
                add_y = ram_rdata;
            end
            S_RCH2: begin
                add_x = r_k2;
                add_y = r_s2;
            end
            S_IDLE, S_RRD0, S_OUT, S_NEXT: begin
                add_x = r_s2;
            end
            default: begin
                add_x = r_s2;
            end
        endcase
    end

    // Sequencer and register updates.
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_key       = r_key;
        n_mix       = r_mix;
        n_tmp_m     = r_tmp_m;
        n_plain     = r_plain;
        n_base      = r_base;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_k2        = r_k2;
        n_idx       = r_idx;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !out_take;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res = '{plain_word: '0, found_seed: '0, status: ST_OK};
                unique case (r_item.req_type)
                    REQ_LOAD: begin
                        n_state = S_OUT;
                    end
                    REQ_START: begin
                        n_key   = r_item.start_seed;
                        n_mix   = MIX_INIT;
                        n_state = S_OUT;
                    end
                    REQ_DECRYPT: begin
                        n_state = S_DMIX;
                    end
                    REQ_RECOVER: begin
                        n_base  = add_sum;
                        n_idx   = '0;
                        n_state = S_RRD0;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_DMIX: begin
                n_tmp_m = add_sum;
                n_state = S_DPLN;
            end
            S_DPLN: begin
                n_plain = r_item.word_a ^ add_sum;
                n_state = S_DKEY;
            end
            S_DKEY: begin
                n_key   = add_sum | (r_key >> KEY_SHR);
                n_state = S_DMX1;
            end
            S_DMX1: begin
                n_mix   = add_sum;
                n_state = S_DMX2;
            end
            S_DMX2: begin
                n_mix            = add_sum;
                n_res.plain_word = r_plain;
                n_state          = S_OUT;
            end
            S_RRD0: begin
                n_state = S_RS1;
            end
            S_RS1: begin
                n_s1    = add_sum;
                n_state = S_RRD1;
            end
            S_RRD1: begin
                n_state = S_RS2;
            end
            S_RS2: begin
                n_s2    = add_sum;
                n_state = S_RCH1;
            end
            S_RCH1: begin
                if ((r_item.word_a ^ add_sum) == r_item.known_plain) begin
                    n_state = S_RK2;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_RK2: begin
                n_k2    = add_sum | (r_s1 >> KEY_SHR);
                n_state = S_RMX1;
            end
            S_RMX1: begin
                n_s2    = add_sum;
                n_state = S_RMX2;
            end
            S_RMX2: begin
                n_s2    = add_sum;
                n_state = S_RMX3;
            end
            S_RMX3: begin
                n_s2    = add_sum;
                n_state = S_RCH2;
            end
            S_RCH2: begin
                if (((r_item.word_b ^ add_sum) & CHECK_MASK) == '0) begin
                    n_res.found_seed = r_s1;
                    n_res.status     = ST_OK;
                    n_state          = S_OUT;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                // Candidates go in rising index order so the lowest one wins.
                if (r_idx == {INDEX_W{1'b1}}) begin
                    n_res.found_seed = '0;
                    n_res.status     = ST_NOT_FOUND;
                    n_state          = S_OUT;
                end else begin
                    n_idx   = r_idx + INDEX_W'(1);
                    n_state = S_RRD0;
                end
            end
            S_OUT: begin
                if (slot_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key       <= '0;
            r_mix       <= MIX_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_key       <= n_key;
            r_mix       <= n_mix;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_tmp_m <= n_tmp_m;
        r_plain <= n_plain;
        r_base  <= n_base;
        r_s1    <= n_s1;
        r_s2    <= n_s2;
        r_k2    <= n_k2;
        r_idx   <= n_idx;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
